### sv/pdc_pkg.sv
// Shared types and constants for the prefix dictionary completion block.
// No dependencies; every other file in sv/ refers to this package by scope.
`default_nettype none

package pdc_pkg;

    localparam int CHAR_W     = 8;   // dictionary and query character
    localparam int MODE_W     = 2;   // input transaction mode
    localparam int IDX_W      = 5;   // entry_index field
    localparam int POS_W      = 4;   // char_position field
    localparam int CNT_W      = 6;   // match counts, candidate_limit, entry_count
    localparam int OLIM_W     = 8;   // output_limit
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;   // widest register

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_END   = 2'd2
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANDIDATE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT     = 2'd2;

    localparam logic [OLIM_W-1:0] OUTPUT_LIMIT_RST    = 8'd255;
    localparam logic [CNT_W-1:0]  CANDIDATE_LIMIT_RST = 6'd32;
    localparam logic [CNT_W-1:0]  ENTRY_COUNT_RST     = 6'd0;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic load;    // write wr_data into the addressed entry
        logic query;   // narrow the match bit with the query character
        logic q_full;  // partial already as long as an entry
        logic clear;   // restart the match bit for a new query
    } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/pdc_if.sv
// Valid/ready stream interfaces for input and result transactions.
// Depends on pdc_pkg for field widths.
`default_nettype none

interface pdc_item_if;
    logic                         valid;
    logic                         ready;
    logic [pdc_pkg::MODE_W-1:0]   mode;
    logic [pdc_pkg::IDX_W-1:0]    entry_index;
    logic [pdc_pkg::POS_W-1:0]    char_position;
    logic [pdc_pkg::CHAR_W-1:0]   character;

    modport source (output valid, mode, entry_index, char_position, character,
                    input ready);
    modport sink   (input valid, mode, entry_index, char_position, character,
                    output ready);
endinterface

interface pdc_result_if;
    logic                         valid;
    logic                         ready;
    logic [pdc_pkg::CHAR_W-1:0]   completion_char;
    logic                         char_valid;
    logic [pdc_pkg::CNT_W-1:0]    match_count;
    logic                         last;

    modport source (output valid, completion_char, char_valid, match_count, last,
                    input ready);
    modport sink   (input valid, completion_char, char_valid, match_count, last,
                    output ready);
endinterface

`default_nettype wire

### sv/prefix_dictionary_completion_top.sv
// Prefix dictionary completion: top level with configuration registers,
// the chain of entry cells and the query-end sequencer.
// Depends on pdc_pkg, pdc_if (pdc_item_if, pdc_result_if) and pdc_cell.
`default_nettype none

// The dictionary holds ENTRIES words of up to ENTRY_LEN bytes, one word per
// cell of a chain. Load transactions write one byte and query transactions
// narrow every cell's match bit at once; neither gives a result. A query-end
// transaction first lets the candidate count ripple through the chain (one
// cell per cycle, which keeps the count in table order and stops it at
// candidate_limit), then walks the common prefix one character per cycle
// while the result side accepts; a stall on the result side holds the walk.
// Input ready is low from the query end until the walk is done. Each result
// carries the match count; the last one has last set.
// Every query end leaves the match state cleared.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, the block itself does not enforce this.
module prefix_dictionary_completion_top #(
    parameter int ENTRIES   = 32,
    parameter int ENTRY_LEN = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    pdc_item_if.sink                                 item,
    pdc_result_if.source                             result,
    input  wire logic                                cfg_we,
    input  wire logic [pdc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = $clog2(ENTRY_LEN);     // character address
    localparam int QW = $clog2(ENTRY_LEN + 1); // query position, saturates at ENTRY_LEN

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // Configuration registers
    logic [pdc_pkg::OLIM_W-1:0] olim_reg;
    logic [pdc_pkg::CNT_W-1:0]  cand_reg;
    logic [pdc_pkg::CNT_W-1:0]  ecount_reg;

    // Sequencer state and registered result
    state_t                     state_reg;
    logic [QW-1:0]              qpos_reg;
    logic [AW-1:0]              pos_reg;
    logic                       pend_reg;
    logic [pdc_pkg::CHAR_W-1:0] pend_char_reg;
    logic [pdc_pkg::CNT_W-1:0]  n_reg;
    logic                       out_valid_reg;
    logic [pdc_pkg::CHAR_W-1:0] out_char_reg;
    logic                       out_cvalid_reg;
    logic [pdc_pkg::CNT_W-1:0]  out_count_reg;
    logic                       out_last_reg;

    // Chain wiring
    pdc_pkg::cell_ctrl_t        ctrl;
    logic                       tok_c [ENTRIES+1];
    logic [pdc_pkg::CNT_W-1:0]  cnt_c [ENTRIES+1];
    logic [ENTRIES-1:0]         first_vec;
    logic [ENTRIES-1:0]         mism_vec;
    logic [ENTRIES-1:0]         in_use_vec;
    logic [pdc_pkg::CHAR_W-1:0] rd_char_c [ENTRIES];
    logic [pdc_pkg::CHAR_W-1:0] fc;
    logic [AW-1:0]              rd_addr;

    logic accept;
    logic q_full;
    logic scan_done;
    logic ofree;
    logic in_j;
    logic emit;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign q_full     = (qpos_reg == QW'(ENTRY_LEN));
    assign scan_done  = (state_reg == ST_SCAN) && tok_c[ENTRIES];
    assign ofree      = !out_valid_reg || result.ready;

    // Query narrowing reads at the query position, the walk at its own pointer.
    assign rd_addr = (state_reg == ST_IDLE) ? qpos_reg[AW-1:0] : pos_reg;

    assign ctrl.load  = accept && (item.mode == pdc_pkg::MODE_LOAD)
                        && (32'(item.char_position) < ENTRY_LEN);
    assign ctrl.query = accept && (item.mode == pdc_pkg::MODE_QUERY)
                        && (item.character != '0);
    assign ctrl.q_full = q_full;
    assign ctrl.clear  = scan_done;

    // Count token enters cell 0 with the query-end transaction.
    assign tok_c[0] = accept && (item.mode == pdc_pkg::MODE_END);
    assign cnt_c[0] = '0;

    for (genvar e = 0; e < ENTRIES; e++)
    begin : g_cell
        assign in_use_vec[e] = (32'(e) < 32'(ecount_reg));

        pdc_cell #(
            .ENTRY_LEN (ENTRY_LEN),
            .IDX       (e)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .entry_index (item.entry_index),
            .wr_addr     (AW'(item.char_position)),
            .wr_data     (item.character),
            .rd_addr     (rd_addr),
            .q_char      (item.character),
            .in_use      (in_use_vec[e]),
            .cand_limit  (cand_reg),
            .tok_in      (tok_c[e]),
            .cnt_in      (cnt_c[e]),
            .first_char  (fc),
            .tok_out     (tok_c[e+1]),
            .cnt_out     (cnt_c[e+1]),
            .first       (first_vec[e]),
            .mism        (mism_vec[e]),
            .rd_char     (rd_char_c[e])
        );
    end

    // Character of the first match at the walk pointer (at most one cell is first).
    always_comb
    begin
        fc = '0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            fc = fc | (first_vec[e] ? rd_char_c[e] : '0);
        end
    end

    // Position still inside the common prefix and inside output_limit - 1.
    assign in_j = (fc != '0) && !(|mism_vec)
                  && ((32'(pos_reg) + 32'd1) < 32'(olim_reg));

    // A result transaction is loaded into the output register this cycle.
    assign emit = ofree && ((((state_reg == ST_WALK) && (pend_reg || !in_j)))
                            || (state_reg == ST_FLUSH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            olim_reg   <= pdc_pkg::OUTPUT_LIMIT_RST;
            cand_reg   <= pdc_pkg::CANDIDATE_LIMIT_RST;
            ecount_reg <= pdc_pkg::ENTRY_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pdc_pkg::CFG_OUTPUT_LIMIT:    olim_reg   <= cfg_data;
                pdc_pkg::CFG_CANDIDATE_LIMIT: cand_reg   <= pdc_pkg::CNT_W'(cfg_data);
                pdc_pkg::CFG_ENTRY_COUNT:     ecount_reg <= pdc_pkg::CNT_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            qpos_reg       <= '0;
            pos_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_char_reg  <= '0;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            out_cvalid_reg <= 1'b0;
            out_count_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.query && !q_full)
                    begin
                        qpos_reg <= qpos_reg + QW'(1);
                    end
                    if (tok_c[0])
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        // Suppressed output reports a count of zero.
                        n_reg     <= (olim_reg == '0) ? '0 : cnt_c[ENTRIES];
                        qpos_reg  <= '0;
                        pos_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (ofree)
                    begin
                        // One-step lookahead: the pending character is last
                        // when this position no longer extends the prefix.
                        if (pend_reg)
                        begin
                            out_char_reg   <= pend_char_reg;
                            out_cvalid_reg <= 1'b1;
                            out_count_reg  <= n_reg;
                            out_last_reg   <= !in_j;
                        end
                        else if (!in_j)
                        begin
                            out_char_reg   <= '0;
                            out_cvalid_reg <= 1'b0;
                            out_count_reg  <= n_reg;
                            out_last_reg   <= 1'b1;
                        end
                        if (in_j)
                        begin
                            pend_reg      <= 1'b1;
                            pend_char_reg <= fc;
                            if (pos_reg == AW'(ENTRY_LEN - 1))
                            begin
                                state_reg <= ST_FLUSH;
                            end
                            else
                            begin
                                pos_reg <= pos_reg + AW'(1);
                            end
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (ofree)
                    begin
                        out_char_reg   <= pend_char_reg;
                        out_cvalid_reg <= 1'b1;
                        out_count_reg  <= n_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.completion_char = out_char_reg;
    assign result.char_valid      = out_cvalid_reg;
    assign result.match_count     = out_count_reg;
    assign result.last            = out_last_reg;

    // A query end holds off further input transactions.
    a_end_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready && (item.mode == pdc_pkg::MODE_END) |=> !item.ready)
        else $error("input accepted right after a query end");

    // After the count ripple only one cell can be the first match.
    a_one_first: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> $onehot0(first_vec))
        else $error("more than one first match in the chain");

    // An empty result always closes its query.
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.char_valid |-> result.last)
        else $error("empty result without last");

    // No characters are emitted without a match.
    a_count_chars: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.match_count == '0) |-> !result.char_valid)
        else $error("character emitted with zero match count");

endmodule

`default_nettype wire

### sv/pdc_cell.sv
// One dictionary entry: its characters, its match bit and its stage of the
// candidate-count chain. Depends on pdc_pkg.
`default_nettype none

module pdc_cell #(
    parameter int ENTRY_LEN = 16,
    parameter int IDX       = 0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire pdc_pkg::cell_ctrl_t               ctrl,
    input  wire logic [pdc_pkg::IDX_W-1:0]         entry_index,
    input  wire logic [$clog2(ENTRY_LEN)-1:0]      wr_addr,
    input  wire logic [pdc_pkg::CHAR_W-1:0]        wr_data,
    input  wire logic [$clog2(ENTRY_LEN)-1:0]      rd_addr,
    input  wire logic [pdc_pkg::CHAR_W-1:0]        q_char,
    input  wire logic                              in_use,
    input  wire logic [pdc_pkg::CNT_W-1:0]         cand_limit,
    input  wire logic                              tok_in,
    input  wire logic [pdc_pkg::CNT_W-1:0]         cnt_in,
    input  wire logic [pdc_pkg::CHAR_W-1:0]        first_char,
    output logic                                   tok_out,
    output logic [pdc_pkg::CNT_W-1:0]              cnt_out,
    output logic                                   first,
    output logic                                   mism,
    output logic [pdc_pkg::CHAR_W-1:0]             rd_char
);

    logic [pdc_pkg::CHAR_W-1:0] chars_reg [ENTRY_LEN];
    logic                       match_reg;
    logic                       tok_reg;
    logic                       sel_reg;
    logic                       first_reg;
    logic [pdc_pkg::CNT_W-1:0]  cnt_reg;
    logic                       hit;
    logic                       considered;

    assign rd_char    = chars_reg[rd_addr];
    assign hit        = ctrl.load && (32'(entry_index) == IDX);
    // Taken while the running count is still below the candidate limit.
    assign considered = match_reg && in_use && (cnt_in < cand_limit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRY_LEN; i++)
            begin
                chars_reg[i] <= '0;
            end
        end
        else if (hit)
        begin
            chars_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b1;
            tok_reg   <= 1'b0;
            sel_reg   <= 1'b0;
            first_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                match_reg <= 1'b1;
            end
            else if (ctrl.query)
            begin
                match_reg <= match_reg && !ctrl.q_full && (rd_char == q_char);
            end
            tok_reg <= tok_in;
            if (tok_in)
            begin
                cnt_reg   <= cnt_in + pdc_pkg::CNT_W'(considered);
                sel_reg   <= considered;
                first_reg <= considered && (cnt_in == '0);
            end
        end
    end

    assign tok_out = tok_reg;
    assign cnt_out = cnt_reg;
    assign first   = first_reg;
    assign mism    = sel_reg && (rd_char != first_char);

endmodule

`default_nettype wire

### dv/pdc_completion_check_pkg.sv
// Scoreboard for the prefix dictionary completion testbench: predicts the result
// transactions of every accepted input and checks what the block returns.
// Depends on pdc_pkg for modes, register indexes and field widths.
package pdc_completion_check_pkg;
    import pdc_pkg::*;

    localparam int DICT_ENTRIES = 32;
    localparam int WORD_BYTES   = 16;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              char_valid;
        logic [CNT_W-1:0]  count;
        logic              last;
    } completion_t;

    class completion_scoreboard;
        logic [CHAR_W-1:0] words [DICT_ENTRIES][WORD_BYTES];
        bit                still_matching [DICT_ENTRIES];
        int unsigned       partial_len;
        logic [OLIM_W-1:0] out_limit;
        logic [CNT_W-1:0]  cand_limit;
        logic [CNT_W-1:0]  entries_in_use;
        completion_t       pending_completions [$];
        int unsigned       mismatches;

        function new();
            foreach (words[e, j])
                words[e][j] = '0;
            restart_query();
            out_limit      = OUTPUT_LIMIT_RST;
            cand_limit     = CANDIDATE_LIMIT_RST;
            entries_in_use = ENTRY_COUNT_RST;
            mismatches     = 0;
        endfunction

        function void restart_query();
            foreach (still_matching[e])
                still_matching[e] = 1'b1;
            partial_len = 0;
        endfunction

        function int unsigned word_length(int unsigned e);
            int unsigned j;
            j = 0;
            while (j < WORD_BYTES && words[e][j] != 0)
                j++;
            return j;
        endfunction

        function int unsigned active_entries();
            return (entries_in_use < DICT_ENTRIES) ? entries_in_use : DICT_ENTRIES;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OUTPUT_LIMIT:    out_limit      = data[OLIM_W-1:0];
                CFG_CANDIDATE_LIMIT: cand_limit     = data[CNT_W-1:0];
                CFG_ENTRY_COUNT:     entries_in_use = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Longest common prefix of the first cand_limit matches, in table order.
        function void complete_query();
            int unsigned used, n, first, lcp, copy, j;
            completion_t c;
            used  = active_entries();
            n     = 0;
            first = 0;
            lcp   = 0;
            for (int unsigned e = 0; e < used && n < cand_limit; e++) begin
                if (!still_matching[e])
                    continue;
                if (n == 0) begin
                    first = e;
                    lcp   = word_length(e);
                end
                else begin
                    j = 0;
                    while (j < lcp && words[e][j] == words[first][j])
                        j++;
                    lcp = j;
                end
                n++;
            end
            restart_query();

            if (n == 0 || out_limit == 0) begin
                c = '{ch: '0, char_valid: 1'b0, count: '0, last: 1'b1};
                pending_completions.push_back(c);
                return;
            end
            copy = (lcp < out_limit) ? lcp : out_limit - 1;
            if (copy == 0) begin
                c = '{ch: '0, char_valid: 1'b0, count: n[CNT_W-1:0], last: 1'b1};
                pending_completions.push_back(c);
                return;
            end
            for (j = 0; j < copy; j++) begin
                c = '{ch: words[first][j], char_valid: 1'b1, count: n[CNT_W-1:0],
                      last: (j + 1 == copy)};
                pending_completions.push_back(c);
            end
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx,
                                logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch);
            case (mode)
                MODE_LOAD:
                    words[idx][pos] = ch;
                MODE_QUERY:
                    if (ch != 0) begin
                        foreach (still_matching[e])
                            if (partial_len >= WORD_BYTES || words[e][partial_len] != ch)
                                still_matching[e] = 1'b0;
                        if (partial_len < WORD_BYTES)
                            partial_len++;
                    end
                MODE_END:
                    complete_query();
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [7:0] exp_v, logic [7:0] act_v);
            if (act_v !== exp_v) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_v, act_v);
                mismatches++;
            end
        endfunction

        function void check_result(completion_t got);
            completion_t exp_c;
            if (pending_completions.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual char %0d count %0d",
                         $time, got.ch, got.count);
                mismatches++;
                return;
            end
            exp_c = pending_completions.pop_front();
            compare("completion_char", exp_c.ch, got.ch);
            compare("char_valid", {7'd0, exp_c.char_valid}, {7'd0, got.char_valid});
            compare("match_count", {2'd0, exp_c.count}, {2'd0, got.count});
            compare("last", {7'd0, exp_c.last}, {7'd0, got.last});
        endfunction

        function int unsigned pending();
            return pending_completions.size();
        endfunction
    endclass

endpackage

### dv/prefix_dictionary_completion_top_tb.sv
// Testbench for prefix_dictionary_completion_top: directed and random load/query
// traffic with random stalls on both streams, checked by completion_scoreboard.
// Depends on pdc_pkg, pdc_if, the RTL top and pdc_completion_check_pkg.
module prefix_dictionary_completion_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;
    import pdc_completion_check_pkg::*;

    // Mode value outside the enum; the block must ignore it.
    localparam logic [MODE_W-1:0]    MODE_RESERVED    = 2'd3;
    // Register index past the three real registers; writes must do nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    localparam int SETTLE_CYCLES  = 48;
    localparam int STALL_LIMIT    = 4000;
    localparam int ITEMS_PER_PASS = 67;
    localparam int PASSES         = 6;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pdc_item_if   item_ch ();
    pdc_result_if result_ch ();

    prefix_dictionary_completion_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    completion_scoreboard sb = new();

    // Percent chance per cycle that each side holds off.
    int unsigned src_idle;
    int unsigned dst_idle;
    // Transactions that do real work (ignored ones are not counted).
    int unsigned items_sent;
    int unsigned stalled_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Result side: ready rerolled every cycle on the falling edge.
    always @(negedge clk)
    begin
        result_ch.ready = ($urandom_range(0, 99) >= dst_idle);
    end

    // Sample completed result transactions on the rising edge, before the
    // block's own registers move.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            sb.check_result('{ch: result_ch.completion_char,
                              char_valid: result_ch.char_valid,
                              count: result_ch.match_count,
                              last: result_ch.last});
    end

    // Watchdog: too many cycles in a row with no transaction on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // All driving tasks are entered and left on a falling edge.
    task automatic send(logic [MODE_W-1:0] m, logic [IDX_W-1:0] idx,
                        logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch);
        while ($urandom_range(0, 99) < src_idle)
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid         = 1'b1;
        item_ch.mode          = m;
        item_ch.entry_index   = idx;
        item_ch.char_position = pos;
        item_ch.character     = ch;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        sb.note_item(m, idx, pos, ch);
        if (!(m == MODE_RESERVED || (m == MODE_QUERY && ch == 0)))
            items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold the input side until every expected result is back, then let the
    // block finish anything that produces no result.
    task automatic wait_quiet();
        item_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly a small alphabet so words share prefixes; now and then any nonzero byte.
    function automatic logic [CHAR_W-1:0] pick_char();
        if ($urandom_range(0, 9) == 0)
            return CHAR_W'($urandom_range(1, 255));
        return CHAR_W'(8'h61 + $urandom_range(0, 2));
    endfunction

    // Favor entries that entry_count actually exposes.
    function automatic int unsigned pick_entry();
        int unsigned used;
        used = sb.active_entries();
        if (used == 0 || $urandom_range(0, 3) == 0)
            return $urandom_range(0, DICT_ENTRIES - 1);
        return $urandom_range(0, used - 1);
    endfunction

    // New word for one entry, built on a prefix of some stored word (possibly its own).
    // Only bytes that change are written, up to the terminator when the word is short.
    task automatic load_word();
        logic [CHAR_W-1:0] word [WORD_BYTES];
        int unsigned e, src, keep, len;
        e    = pick_entry();
        src  = pick_entry();
        keep = $urandom_range(0, sb.word_length(src));
        if ($urandom_range(0, 5) == 0)
            len = WORD_BYTES;
        else
            len = $urandom_range(keep, (keep + 4 > WORD_BYTES) ? WORD_BYTES : keep + 4);
        for (int unsigned j = 0; j < WORD_BYTES; j++)
            word[j] = (j < keep) ? sb.words[src][j] : ((j < len) ? pick_char() : 8'h00);
        for (int unsigned j = 0; j < WORD_BYTES && j <= len; j++)
            if (word[j] !== sb.words[e][j])
                send(MODE_LOAD, IDX_W'(e), POS_W'(j), word[j]);
    endtask

    // Query with a real prefix of a stored word, sometimes overrunning it,
    // then end the query. Index and position fields are don't-care here.
    task automatic query_prefix();
        int unsigned s, len, k, extra;
        s   = pick_entry();
        len = sb.word_length(s);
        k   = ($urandom_range(0, 2) == 0) ? len : $urandom_range(0, len);
        for (int unsigned j = 0; j < k; j++)
            send(MODE_QUERY, IDX_W'($urandom), POS_W'($urandom), sb.words[s][j]);
        extra = 0;
        if ($urandom_range(0, 4) == 0 || (k == len && $urandom_range(0, 1) == 0))
            extra = $urandom_range(1, 3);
        for (int unsigned j = 0; j < extra; j++)
            send(MODE_QUERY, IDX_W'($urandom), POS_W'($urandom), pick_char());
        send(MODE_END, IDX_W'($urandom), POS_W'($urandom), CHAR_W'($urandom));
    endtask

    // Unstructured transactions: stray loads, zero query characters, the
    // reserved mode and bare query ends.
    task automatic noise();
        case ($urandom_range(0, 3))
            0: send(MODE_LOAD, IDX_W'($urandom), POS_W'($urandom), CHAR_W'($urandom));
            1: send(MODE_QUERY, IDX_W'($urandom), POS_W'($urandom),
                    ($urandom_range(0, 3) == 0) ? 8'h00 : CHAR_W'($urandom));
            2: send(MODE_RESERVED, IDX_W'($urandom), POS_W'($urandom), CHAR_W'($urandom));
            default: send(MODE_END, IDX_W'($urandom), POS_W'($urandom), CHAR_W'($urandom));
        endcase
    endtask

    initial
    begin
        int unsigned target;
        src_idle                = 14;
        dst_idle                = 61;
        items_sent              = 0;
        stalled_cycles          = 0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_data                = '0;
        item_ch.valid           = 1'b0;
        item_ch.mode            = MODE_LOAD;
        item_ch.entry_index     = '0;
        item_ch.char_position   = '0;
        item_ch.character       = '0;
        result_ch.ready         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Reset leaves entry_count at 0, so nothing matches.
        send(MODE_END, '0, '0, '0);
        wait_quiet();
        // An oversized entry_count acts as all entries; the spare index is a no-op.
        write_reg(CFG_ENTRY_COUNT, 8'd63);
        write_reg(CFG_UNUSED_INDEX, 8'hFF);
        send(MODE_LOAD, 5'd31, 4'd15, 8'hFF);
        send(MODE_LOAD, 5'd31, 4'd0, 8'h61);   // entry 31: "a"
        send(MODE_LOAD, 5'd0, 4'd0, 8'h61);    // entry 0: "ab"
        send(MODE_LOAD, 5'd0, 4'd1, 8'h62);
        send(MODE_LOAD, 5'd1, 4'd0, 8'h61);    // entry 1: "ac"
        send(MODE_LOAD, 5'd1, 4'd1, 8'h63);
        // Zero query character and reserved mode are both ignored.
        send(MODE_QUERY, 5'd0, 4'd0, 8'h00);
        send(MODE_RESERVED, 5'd31, 4'd15, 8'hFF);
        // Empty partial: all 32 match, empty words make the prefix empty.
        send(MODE_END, '0, '0, '0);
        // "a": three matches, prefix "a".
        send(MODE_QUERY, '0, '0, 8'h61);
        send(MODE_END, '0, '0, '0);
        // "ab": only entry 0, two characters out.
        send(MODE_QUERY, '0, '0, 8'h61);
        send(MODE_QUERY, '0, '0, 8'h62);
        send(MODE_END, '0, '0, '0);
        // "abx": partial runs past entry 0, so no match.
        send(MODE_QUERY, '0, '0, 8'h61);
        send(MODE_QUERY, '0, '0, 8'h62);
        send(MODE_QUERY, '0, '0, 8'h78);
        send(MODE_END, '0, '0, '0);
        send(MODE_LOAD, 5'd31, 4'd15, 8'h00);

        // Random passes. Each one first drains the block (the sender sits idle
        // until every expected result is in), then reprograms the registers.
        // Stall profile: sender light / receiver heavy, then swapped, then none.
        for (int p = 0; p < PASSES; p++)
        begin
            src_idle = (p < 2) ? 14 : ((p < 4) ? 61 : 0);
            dst_idle = (p < 2) ? 61 : ((p < 4) ? 14 : 0);
            wait_quiet();
            case (p)
                0:
                begin
                    write_reg(CFG_OUTPUT_LIMIT, 8'd255);
                    write_reg(CFG_CANDIDATE_LIMIT, 8'd32);
                    write_reg(CFG_ENTRY_COUNT, 8'd32);
                end
                1:
                begin
                    write_reg(CFG_OUTPUT_LIMIT, 8'd0);    // output suppressed
                    write_reg(CFG_CANDIDATE_LIMIT, 8'd32);
                    write_reg(CFG_ENTRY_COUNT, 8'd16);
                end
                2:
                begin
                    write_reg(CFG_OUTPUT_LIMIT, 8'd1);    // room for no characters
                    write_reg(CFG_CANDIDATE_LIMIT, 8'd1);
                    write_reg(CFG_ENTRY_COUNT, 8'd32);
                end
                3:
                begin
                    write_reg(CFG_OUTPUT_LIMIT, 8'd4);
                    write_reg(CFG_CANDIDATE_LIMIT, 8'd0); // nothing counted
                    write_reg(CFG_ENTRY_COUNT, 8'd8);
                end
                4:
                begin
                    write_reg(CFG_OUTPUT_LIMIT, 8'd200);
                    write_reg(CFG_CANDIDATE_LIMIT, 8'd3);
                    write_reg(CFG_ENTRY_COUNT, 8'd63);
                end
                default:
                begin
                    write_reg(CFG_OUTPUT_LIMIT, CFG_DATA_W'($urandom_range(0, 255)));
                    write_reg(CFG_CANDIDATE_LIMIT, CFG_DATA_W'($urandom_range(0, 32)));
                    write_reg(CFG_ENTRY_COUNT, CFG_DATA_W'($urandom_range(0, 32)));
                end
            endcase
            // Mostly well-formed load and query sequences, a little noise.
            target = items_sent + ITEMS_PER_PASS;
            while (items_sent < target)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6:
                        load_word();
                    17, 18, 19:
                        noise();
                    default:
                        query_prefix();
                endcase
            end
        end

        // Drain, then give the block time to show any stray result.
        wait_quiet();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
sv/pdc_pkg.sv
sv/pdc_if.sv
sv/pdc_cell.sv
sv/prefix_dictionary_completion_top.sv
dv/pdc_completion_check_pkg.sv
dv/prefix_dictionary_completion_top_tb.sv
